FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Each use names the label, clock, active-low reset, antecedent and consequent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define TD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("td assertion failed");

// Next-cycle implication.
`define TD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("td assertion failed");

`endif

FILE: rtl/td_pkg.sv
// ----------------------------------------------------------------------------
// td_pkg
// Widths, codes, micro-operations and control/status types of the tracking
// differentiator.
// ----------------------------------------------------------------------------
`default_nettype none

package td_pkg;

    // signal format: signed Q16.16
    localparam int SW     = 32;
    localparam int FB     = 16;
    localparam int OPW    = 2;
    localparam int CFG_IW = 2;
    localparam int CFGW   = 32;

    // internal widths
    localparam int RW    = 31;        // accel limit r
    localparam int DTW   = 32;        // step period dt
    localparam int HW    = 35;        // horizon h (5*dt needs 35 bits)
    localparam int DW    = 34;        // d = r*h/2^32
    localparam int D0W   = 37;        // d0 = d*h/2^32
    localparam int YW    = 37;        // signed y, a
    localparam int SQW   = 68;        // d*d
    localparam int NW    = 70;        // radicand
    localparam int RTW   = NW / 2;    // root
    localparam int SREMW = RTW + 2;   // root remainder
    localparam int QW    = 35;        // divider quotient / remainder
    localparam int MAW   = 36;        // multiplier operand
    localparam int PW    = 2 * MAW;   // product

    localparam int ITER_STEPS = 35;
    localparam int CNTW       = $clog2(ITER_STEPS + 1);

    localparam logic [RW-1:0]  R_FALLBACK  = RW'(64'd1 << FB);
    localparam logic [DTW-1:0] DT_FALLBACK = 32'd4294967;

    // operation codes
    localparam logic [OPW-1:0] OP_STEP    = 2'd0;
    localparam logic [OPW-1:0] OP_PRELOAD = 2'd1;
    localparam logic [OPW-1:0] OP_CLEAR   = 2'd2;
    localparam logic [OPW-1:0] OP_HOLD    = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_ACCEL   = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_PERIOD  = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_HORIZON = 2'd2;

    typedef enum logic [4:0] {
        U_NOP, U_LATCH, U_SIMPLE,
        U_MRH, U_MDH, U_MXH, U_MDD, U_MRY, U_SUM,
        U_SQ_INIT, U_SQ_STEP, U_SQ_END,
        U_DV1_INIT, U_DV2_INIT, U_DV_STEP, U_DV1_END,
        U_ACCA, U_ACC_SAT, U_ACC_ZERO, U_MRQ, U_ACC_DIV,
        U_MX1, U_MX2, U_FIN
    } t_uop;

    typedef enum logic [4:0] {
        S_IDLE, S_DISP, S_SIMPLE,
        S_MRH, S_MDH, S_MXH, S_MDD, S_MRY, S_SUM,
        S_SQ_INIT, S_SQ_STEP, S_SQ_END,
        S_DV1_INIT, S_DV1_STEP, S_DV1_END,
        S_ACCA, S_ACHK, S_ACC_SAT, S_ACC_ZERO,
        S_DV2_INIT, S_DV2_STEP, S_MRQ, S_ACC_DIV,
        S_MX1, S_MX2, S_FIN
    } t_state;

    typedef struct packed {
        t_uop uop;
    } t_cmd;

    typedef struct packed {
        logic [OPW-1:0] op;
        logic           primed;
        logic           big_y;     // |y| > d0
        logic           a_big;     // |a| > d
        logic           d_zero;
        logic           out_free;
    } t_stat;

endpackage

`default_nettype wire

FILE: rtl/td_if.sv
// ----------------------------------------------------------------------------
// td_if
// Channel interfaces: sample input, result output, configuration write.
// ----------------------------------------------------------------------------
`default_nettype none

interface td_in_if;
    logic                           valid;
    logic                           ready;
    logic [td_pkg::OPW-1:0]         operation;
    logic signed [td_pkg::SW-1:0]   sample;

    modport source(output valid, operation, sample, input ready);
    modport sink(input valid, operation, sample, output ready);
endinterface

interface td_out_if;
    logic                           valid;
    logic                           ready;
    logic signed [td_pkg::SW-1:0]   tracked_out;
    logic signed [td_pkg::SW-1:0]   rate_out;
    logic                           rebuilt;

    modport source(output valid, tracked_out, rate_out, rebuilt, input ready);
    modport sink(input valid, tracked_out, rate_out, rebuilt, output ready);
endinterface

interface td_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [td_pkg::CFG_IW-1:0]      index;
    logic [td_pkg::CFGW-1:0]        data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/tracking_differentiator.sv
// ----------------------------------------------------------------------------
// tracking_differentiator
// Fixed-point tracking differentiator (fhan) with preload, clear and
// overflow rebuild.
// ----------------------------------------------------------------------------
// One item is in flight at a time. Preload, clear, hold and the first step
// after a clear pass from dispatch through one simple state to the result.
// A primed step runs the 35-step bit-serial square root or the 35-step
// divider and, unless the acceleration saturates or d is zero, a second
// 35-step division for the linear zone; around these, its multiplies run one
// after another on one shared 36x36 multiplier. A finished word sits in the
// output register while the next item is accepted. Configuration writes are
// always ready and must only occur while no item is in flight.
`default_nettype none

module tracking_differentiator (
    input  var logic    i_clk,
    input  var logic    i_rst_n,
    td_in_if.sink       i_in,
    td_out_if.source    o_out,
    td_cfg_if.sink      i_cfg
);
    import td_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    td_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    td_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg_we      (i_cfg.valid),
        .i_cfg_index   (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .i_operation   (i_in.operation),
        .i_sample      (i_in.sample),
        .o_tracked_out (o_out.tracked_out),
        .o_rate_out    (o_out.rate_out),
        .o_rebuilt     (o_out.rebuilt),
        .o_valid       (o_out.valid),
        .i_ready       (o_out.ready)
    );

    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;

endmodule

`default_nettype wire

FILE: rtl/td_ctrl.sv
// ----------------------------------------------------------------------------
// td_ctrl
// Sequencer: walks one item through the datapath micro-operations.
// ----------------------------------------------------------------------------
`default_nettype none

module td_ctrl (
    input  var logic          i_clk,
    input  var logic          i_rst_n,
    input  var logic          i_in_valid,
    output logic              o_in_ready,
    input  var td_pkg::t_stat i_stat,
    output td_pkg::t_cmd      o_cmd
);
    import td_pkg::*;
    `include "assert_macros.svh"

    t_state          r_state, n_state;
    logic [CNTW-1:0] r_cnt;
    logic            last_iter;

    assign last_iter = (r_cnt == CNTW'(ITER_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (r_state == S_SQ_INIT || r_state == S_DV1_INIT ||
                     r_state == S_DV2_INIT) begin
            r_cnt <= '0;
        end else if (r_state == S_SQ_STEP || r_state == S_DV1_STEP ||
                     r_state == S_DV2_STEP) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (i_in_valid) n_state = S_DISP;
            S_DISP: begin
                if (i_stat.op == OP_STEP && i_stat.primed) n_state = S_MRH;
                else n_state = S_SIMPLE;
            end
            S_SIMPLE:   if (i_stat.out_free) n_state = S_IDLE;
            S_MRH:      n_state = S_MDH;
            S_MDH:      n_state = S_MXH;
            S_MXH:      n_state = S_MDD;
            S_MDD:      n_state = S_MRY;
            S_MRY:      n_state = S_SUM;
            S_SUM:      n_state = i_stat.big_y ? S_SQ_INIT : S_DV1_INIT;
            S_SQ_INIT:  n_state = S_SQ_STEP;
            S_SQ_STEP:  if (last_iter) n_state = S_SQ_END;
            S_SQ_END:   n_state = S_ACCA;
            S_DV1_INIT: n_state = S_DV1_STEP;
            S_DV1_STEP: if (last_iter) n_state = S_DV1_END;
            S_DV1_END:  n_state = S_ACCA;
            S_ACCA:     n_state = S_ACHK;
            S_ACHK: begin
                priority if (i_stat.a_big) n_state = S_ACC_SAT;
                else if (i_stat.d_zero)    n_state = S_ACC_ZERO;
                else                       n_state = S_DV2_INIT;
            end
            S_ACC_SAT:  n_state = S_MX1;
            S_ACC_ZERO: n_state = S_MX1;
            S_DV2_INIT: n_state = S_DV2_STEP;
            S_DV2_STEP: if (last_iter) n_state = S_MRQ;
            S_MRQ:      n_state = S_ACC_DIV;
            S_ACC_DIV:  n_state = S_MX1;
            S_MX1:      n_state = S_MX2;
            S_MX2:      n_state = S_FIN;
            S_FIN:      if (i_stat.out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        o_cmd.uop  = U_NOP;
        unique case (r_state)
            S_IDLE:     o_cmd.uop = i_in_valid ? U_LATCH : U_NOP;
            S_SIMPLE:   o_cmd.uop = i_stat.out_free ? U_SIMPLE : U_NOP;
            S_MRH:      o_cmd.uop = U_MRH;
            S_MDH:      o_cmd.uop = U_MDH;
            S_MXH:      o_cmd.uop = U_MXH;
            S_MDD:      o_cmd.uop = U_MDD;
            S_MRY:      o_cmd.uop = U_MRY;
            S_SUM:      o_cmd.uop = U_SUM;
            S_SQ_INIT:  o_cmd.uop = U_SQ_INIT;
            S_SQ_STEP:  o_cmd.uop = U_SQ_STEP;
            S_SQ_END:   o_cmd.uop = U_SQ_END;
            S_DV1_INIT: o_cmd.uop = U_DV1_INIT;
            S_DV1_STEP: o_cmd.uop = U_DV_STEP;
            S_DV1_END:  o_cmd.uop = U_DV1_END;
            S_ACCA:     o_cmd.uop = U_ACCA;
            S_ACC_SAT:  o_cmd.uop = U_ACC_SAT;
            S_ACC_ZERO: o_cmd.uop = U_ACC_ZERO;
            S_DV2_INIT: o_cmd.uop = U_DV2_INIT;
            S_DV2_STEP: o_cmd.uop = U_DV_STEP;
            S_MRQ:      o_cmd.uop = U_MRQ;
            S_ACC_DIV:  o_cmd.uop = U_ACC_DIV;
            S_MX1:      o_cmd.uop = U_MX1;
            S_MX2:      o_cmd.uop = U_MX2;
            S_FIN:      o_cmd.uop = i_stat.out_free ? U_FIN : U_NOP;
            default:    o_cmd.uop = U_NOP;
        endcase
    end

    `TD_ASSERT_NEXT(a_accept_dispatch, i_clk, i_rst_n, r_state == S_IDLE && i_in_valid, r_state == S_DISP)
    `TD_ASSERT_IMPL(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CNTW'(ITER_STEPS))

endmodule

`default_nettype wire

FILE: rtl/td_dp.sv
// ----------------------------------------------------------------------------
// td_dp
// Datapath: config registers, state, shared multiplier, bit-serial square
// root and restoring divider, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module td_dp (
    input  var logic                          i_clk,
    input  var logic                          i_rst_n,
    input  var td_pkg::t_cmd                  i_cmd,
    output td_pkg::t_stat                     o_stat,
    input  var logic                          i_cfg_we,
    input  var logic [td_pkg::CFG_IW-1:0]     i_cfg_index,
    input  var logic [td_pkg::CFGW-1:0]       i_cfg_data,
    input  var logic [td_pkg::OPW-1:0]        i_operation,
    input  var logic signed [td_pkg::SW-1:0]  i_sample,
    output logic signed [td_pkg::SW-1:0]      o_tracked_out,
    output logic signed [td_pkg::SW-1:0]      o_rate_out,
    output logic                              o_rebuilt,
    output logic                              o_valid,
    input  var logic                          i_ready
);
    import td_pkg::*;
    `include "assert_macros.svh"

    // configuration
    logic [RW-1:0]  r_accel;
    logic [DTW-1:0] r_period;
    logic [DTW-1:0] r_horizon;

    // filter state
    logic signed [SW-1:0] r_x1, r_x2;
    logic                 r_primed;

    // item and working registers
    logic [OPW-1:0]        r_op;
    logic signed [SW-1:0]  r_sample;
    logic [PW-1:0]         r_prod;
    logic [DW-1:0]         r_d;
    logic [D0W-1:0]        r_d0;
    logic signed [YW-1:0]  r_y;
    logic [SQW-1:0]        r_sq;
    logic [NW-1:0]         r_n;
    logic [SREMW-1:0]      r_srem;
    logic [RTW-1:0]        r_root;
    logic [QW-1:0]         r_dden, r_drem, r_dnum, r_q, r_m;
    logic signed [YW-1:0]  r_a;
    logic signed [SW-1:0]  r_acc;
    logic signed [SW:0]    r_n1;

    // output register
    logic signed [SW-1:0]  r_out_x1, r_out_x2;
    logic                  r_out_flag, r_ovalid;

    logic           bad_gain;
    logic [RW-1:0]  eff_r;
    logic [DTW-1:0] eff_dt;
    logic [HW-1:0]  h5, eff_h;
    logic [SW-1:0]  x2_mag, acc_mag;
    logic [YW-1:0]  ay, aa;
    logic signed [SW:0] e_val;
    logic [MAW-1:0] ma, mb;
    logic [PW-1:0]  mul_out;
    logic [SREMW+1:0] srem_sh, sq_trial;
    logic             sq_take;
    logic [QW:0]    drs;
    logic           dtake;
    logic signed [SW:0] n2;
    logic           ovf, out_load;

    // effective gains; bad gains fall back to defaults
    assign bad_gain = (r_accel == '0) || (r_period == '0);
    assign eff_r    = bad_gain ? R_FALLBACK : r_accel;
    assign eff_dt   = bad_gain ? DT_FALLBACK : r_period;
    assign h5       = HW'(eff_dt) + {1'b0, eff_dt, 2'b00};
    assign eff_h    = (!bad_gain && r_horizon != '0) ? HW'(r_horizon) : h5;

    assign x2_mag  = r_x2[SW-1] ? SW'(-r_x2) : SW'(r_x2);
    assign acc_mag = r_acc[SW-1] ? SW'(-r_acc) : SW'(r_acc);
    assign ay      = r_y[YW-1] ? YW'(-r_y) : YW'(r_y);
    assign aa      = r_a[YW-1] ? YW'(-r_a) : YW'(r_a);
    assign e_val   = {r_x1[SW-1], r_x1} - {r_sample[SW-1], r_sample};

    // shared multiplier operand select
    always_comb begin
        ma = '0;
        mb = '0;
        unique case (i_cmd.uop)
            U_MRH: begin ma = MAW'(eff_r);         mb = MAW'(eff_h);       end
            U_MDH: begin ma = MAW'(r_prod[65:32]); mb = MAW'(eff_h);       end
            U_MXH: begin ma = MAW'(x2_mag);        mb = MAW'(eff_h);       end
            U_MDD: begin ma = MAW'(r_d);           mb = MAW'(r_d);         end
            U_MRY: begin ma = MAW'(eff_r);         mb = ay[MAW-1:0];       end
            U_MRQ: begin ma = MAW'(eff_r);         mb = MAW'(r_q);         end
            U_MX1: begin ma = MAW'(x2_mag);        mb = MAW'(eff_dt);      end
            U_MX2: begin ma = MAW'(acc_mag);       mb = MAW'(eff_dt);      end
            default: begin ma = '0;                mb = '0;                end
        endcase
    end
    assign mul_out = PW'(ma) * PW'(mb);

    // square root digit step
    assign srem_sh  = {r_srem, r_n[NW-1:NW-2]};
    assign sq_trial = (SREMW+2)'({r_root, 2'b01});
    assign sq_take  = (srem_sh >= sq_trial);

    // restoring divider step
    assign drs   = {r_drem, r_dnum[QW-1]};
    assign dtake = (drs >= {1'b0, r_dden});

    assign n2  = {r_x2[SW-1], r_x2} +
                 (r_acc[SW-1] ? -$signed({1'b0, r_prod[63:32]})
                              :  $signed({1'b0, r_prod[63:32]}));
    assign ovf = (r_n1[SW] != r_n1[SW-1]) || (n2[SW] != n2[SW-1]);

    assign out_load = (i_cmd.uop == U_SIMPLE) || (i_cmd.uop == U_FIN);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel   <= R_FALLBACK;
            r_period  <= DT_FALLBACK;
            r_horizon <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ACCEL:   r_accel   <= i_cfg_data[RW-1:0];
                CFG_PERIOD:  r_period  <= i_cfg_data;
                CFG_HORIZON: r_horizon <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    // filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1     <= '0;
            r_x2     <= '0;
            r_primed <= 1'b0;
        end else if (i_cmd.uop == U_SIMPLE) begin
            unique case (r_op)
                OP_STEP, OP_PRELOAD: begin
                    r_x1     <= r_sample;
                    r_x2     <= '0;
                    r_primed <= 1'b1;
                end
                OP_CLEAR: begin
                    r_x1     <= '0;
                    r_x2     <= '0;
                    r_primed <= 1'b0;
                end
                default: ;
            endcase
        end else if (i_cmd.uop == U_FIN) begin
            // rebuild on overflow
            r_x1 <= ovf ? r_sample : r_n1[SW-1:0];
            r_x2 <= ovf ? '0 : n2[SW-1:0];
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.uop == U_MRH || i_cmd.uop == U_MDH || i_cmd.uop == U_MXH ||
            i_cmd.uop == U_MDD || i_cmd.uop == U_MRY || i_cmd.uop == U_MRQ ||
            i_cmd.uop == U_MX1 || i_cmd.uop == U_MX2) begin
            r_prod <= mul_out;
        end
        unique case (i_cmd.uop)
            U_LATCH: begin
                r_op     <= i_operation;
                r_sample <= i_sample;
            end
            U_MDH: r_d  <= r_prod[65:32];
            U_MXH: r_d0 <= r_prod[68:32];
            U_MDD: begin
                r_y <= YW'(e_val) +
                       (r_x2[SW-1] ? -$signed(YW'(r_prod[65:32]))
                                   :  $signed(YW'(r_prod[65:32])));
            end
            U_MRY: r_sq <= r_prod[SQW-1:0];
            U_SUM: r_n  <= NW'(r_sq) + NW'({r_prod[65:0], 3'b000});
            U_SQ_INIT: begin
                r_srem <= '0;
                r_root <= '0;
            end
            U_SQ_STEP: begin
                r_srem <= sq_take ? SREMW'(srem_sh - sq_trial) : SREMW'(srem_sh);
                r_root <= {r_root[RTW-2:0], sq_take};
                r_n    <= {r_n[NW-3:0], 2'b00};
            end
            U_SQ_END: r_m <= QW'((r_root - RTW'(r_d)) >> 1);
            U_DV1_INIT: begin
                r_drem <= QW'(ay >> 3);
                r_dnum <= {ay[2:0], 32'd0};
                r_dden <= QW'(eff_h);
                r_q    <= '0;
            end
            U_DV2_INIT: begin
                r_drem <= QW'(aa >> 3);
                r_dnum <= {aa[2:0], 32'd0};
                r_dden <= QW'(r_d);
                r_q    <= '0;
            end
            U_DV_STEP: begin
                r_drem <= dtake ? QW'(drs - {1'b0, r_dden}) : QW'(drs);
                r_dnum <= {r_dnum[QW-2:0], 1'b0};
                r_q    <= {r_q[QW-2:0], dtake};
            end
            U_DV1_END: r_m <= r_q;
            U_ACCA: begin
                r_a <= YW'(r_x2) + (r_y[YW-1] ? -$signed(YW'(r_m)) : $signed(YW'(r_m)));
            end
            U_ACC_SAT: begin
                r_acc <= (r_a > 0) ? -$signed(SW'(eff_r)) : $signed(SW'(eff_r));
            end
            U_ACC_ZERO: r_acc <= '0;
            U_ACC_DIV: begin
                r_acc <= (r_a > 0) ? -$signed(SW'(r_prod[62:32]))
                                   :  $signed(SW'(r_prod[62:32]));
            end
            U_MX2: begin
                r_n1 <= {r_x1[SW-1], r_x1} +
                        (r_x2[SW-1] ? -$signed({1'b0, r_prod[63:32]})
                                    :  $signed({1'b0, r_prod[63:32]}));
            end
            default: ;
        endcase
    end

    // output word
    always_ff @(posedge i_clk) begin
        if (i_cmd.uop == U_SIMPLE) begin
            r_out_flag <= 1'b0;
            unique case (r_op)
                OP_STEP, OP_PRELOAD: begin
                    r_out_x1 <= r_sample;
                    r_out_x2 <= '0;
                end
                OP_CLEAR: begin
                    r_out_x1 <= '0;
                    r_out_x2 <= '0;
                end
                default: begin
                    r_out_x1 <= r_x1;
                    r_out_x2 <= r_x2;
                end
            endcase
        end else if (i_cmd.uop == U_FIN) begin
            r_out_x1   <= ovf ? r_sample : r_n1[SW-1:0];
            r_out_x2   <= ovf ? '0 : n2[SW-1:0];
            r_out_flag <= ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_tracked_out = r_out_x1;
    assign o_rate_out    = r_out_x2;
    assign o_rebuilt     = r_out_flag;
    assign o_valid       = r_ovalid;

    assign o_stat.op       = r_op;
    assign o_stat.primed   = r_primed;
    assign o_stat.big_y    = (ay > r_d0);
    assign o_stat.a_big    = (aa > YW'(r_d));
    assign o_stat.d_zero   = (r_d == '0);
    assign o_stat.out_free = !r_ovalid || i_ready;

    `TD_ASSERT_IMPL(a_div_rem_lt_den, i_clk, i_rst_n, i_cmd.uop == U_DV_STEP, r_drem < r_dden)
    `TD_ASSERT_IMPL(a_root_ge_d, i_clk, i_rst_n, i_cmd.uop == U_SQ_END, r_root >= RTW'(r_d))

endmodule

`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tracking differentiator. A clocked driver
// sends queued sample words in random bursts, and a clocked monitor compares
// each result word with an in-bench fixed-point fhan tracker. The run steps
// through several gain settings, the extremes among them.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import td_pkg::*;

    localparam longint    RUN_LIMIT = 3000000;
    localparam bit [63:0] SAT_MAG   = 64'h4000_0000_0000_0000;
    localparam longint    SIG_HI    = 64'sd2147483647;
    localparam longint    SIG_LO    = -64'sd2147483648;

    typedef logic [127:0] u128_t;

    typedef struct {
        logic [OPW-1:0]       op;
        logic signed [SW-1:0] sample;
    } td_word_t;

    typedef struct {
        logic signed [SW-1:0] tracked;
        logic signed [SW-1:0] rate;
        logic                 rebuilt;
    } td_result_t;

    logic   i_clk = 1'b0;
    logic   i_rst_n;
    longint cycle_cnt = 0;
    int     n_err = 0;

    td_in_if  in_if();
    td_out_if out_if();
    td_cfg_if cfg_if();

    tracking_differentiator u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if.sink),
        .o_out  (out_if.source),
        .i_cfg  (cfg_if.sink)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // tracker copy: gains and state
    logic [63:0] accel_r, period_dt, horizon_h;
    longint      track_x1 = 0, track_x2 = 0;
    bit          track_primed = 1'b0;

    td_word_t   send_q[$];
    td_result_t result_q[$];

    // |m*b| / 2^32, saturated
    function automatic logic [63:0] scale_q32(logic [63:0] m, logic [63:0] b);
        u128_t p;
        p = (u128_t'(m) * u128_t'(b)) >> 32;
        return (p > u128_t'(SAT_MAG)) ? SAT_MAG : p[63:0];
    endfunction

    function automatic longint sscale_q32(longint a, logic [63:0] b);
        logic [63:0] m;
        m = scale_q32(a < 0 ? 64'(-a) : 64'(a), b);
        return a < 0 ? -longint'(m) : longint'(m);
    endfunction

    // num * 2^32 / den, saturated
    function automatic logic [63:0] ratio_q32(logic [63:0] num, logic [63:0] den);
        u128_t q;
        if (num / den >= 64'd1 << 30) return SAT_MAG;
        q = {num, 32'b0} / u128_t'(den);
        return q[63:0];
    endfunction

    function automatic logic [63:0] root_floor(u128_t n);
        logic [63:0] root, c;
        root = 0;
        for (int b = 63; b >= 0; b--) begin
            c = root | (64'd1 << b);
            if (u128_t'(c) * u128_t'(c) <= n) root = c;
        end
        return root;
    endfunction

    function automatic longint fhan_accel(longint e, longint x2, logic [63:0] r,
                                          logic [63:0] h);
        logic [63:0] d, d0, ay, a0, m, aa;
        u128_t       p, rad;
        longint      y, a;
        p   = (u128_t'(r) * u128_t'(h)) >> 32;
        d   = p[63:0];
        d0  = scale_q32(d, h);
        y   = e + sscale_q32(x2, h);
        if (y > longint'(SAT_MAG)) y = longint'(SAT_MAG);
        if (y < -longint'(SAT_MAG)) y = -longint'(SAT_MAG);
        ay  = y < 0 ? 64'(-y) : 64'(y);
        rad = u128_t'(d) * u128_t'(d) + ((u128_t'(r) * u128_t'(ay)) << 3);
        a0  = root_floor(rad);
        m   = (ay > d0) ? (a0 - d) >> 1 : ratio_q32(ay, h);
        a   = x2 + (y < 0 ? -longint'(m) : longint'(m));
        aa  = a < 0 ? 64'(-a) : 64'(a);
        if (aa > d) return a > 0 ? -longint'(r) : longint'(r);
        if (d == 0) return 0;
        m = (r * ratio_q32(aa, d)) >> 32;
        return a > 0 ? -longint'(m) : longint'(m);
    endfunction

    // advance the tracker by one word and queue its result
    function automatic void advance_tracker(td_word_t w);
        longint      s, acc, n1, n2;
        logic [63:0] r, dt, h;
        td_result_t  res;
        s = longint'(w.sample);
        res.rebuilt = 1'b0;
        case (w.op)
            OP_STEP: begin
                if (!track_primed) begin
                    track_x1 = s;
                    track_x2 = 0;
                    track_primed = 1'b1;
                end else begin
                    if (accel_r == 0 || period_dt == 0) begin
                        r  = 64'(R_FALLBACK);
                        dt = 64'(DT_FALLBACK);
                        h  = 5 * dt;
                    end else begin
                        r  = accel_r;
                        dt = period_dt;
                        h  = horizon_h != 0 ? horizon_h : 5 * dt;
                    end
                    acc = fhan_accel(track_x1 - s, track_x2, r, h);
                    n1  = track_x1 + sscale_q32(track_x2, dt);
                    n2  = track_x2 + sscale_q32(acc, dt);
                    if (n1 > SIG_HI || n1 < SIG_LO || n2 > SIG_HI || n2 < SIG_LO) begin
                        n1 = s;
                        n2 = 0;
                        res.rebuilt = 1'b1;
                    end
                    track_x1 = n1;
                    track_x2 = n2;
                end
            end
            OP_PRELOAD: begin
                track_x1 = s;
                track_x2 = 0;
                track_primed = 1'b1;
            end
            OP_CLEAR: begin
                track_x1 = 0;
                track_x2 = 0;
                track_primed = 1'b0;
            end
            default: ;
        endcase
        res.tracked = track_x1[SW-1:0];
        res.rate    = track_x2[SW-1:0];
        result_q.push_back(res);
    endfunction

    // driver: bursts of words with random gaps
    int burst_left = 1, gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid     <= 1'b0;
            in_if.operation <= OP_HOLD;
            in_if.sample    <= '0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                advance_tracker(send_q.pop_front());
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 120);
                end
            end else if (!in_if.valid && gap_left > 0) begin
                gap_left--;
            end
            if (gap_left == 0 && send_q.size() > 0) begin
                in_if.valid     <= 1'b1;
                in_if.operation <= send_q[0].op;
                in_if.sample    <= send_q[0].sample;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern: switch mode every so often
    int stall_mode = 0, mode_left = 0;
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(50, 600);
        end else begin
            mode_left--;
        end
        case (stall_mode)
            0:       out_if.ready <= 1'b1;
            1:       out_if.ready <= $urandom_range(0, 1);
            default: out_if.ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // monitor
    always @(posedge i_clk) begin
        td_result_t want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (result_q.size() == 0) begin
                $error("result word with nothing expected");
                n_err++;
            end else begin
                want = result_q.pop_front();
                if (out_if.tracked_out !== want.tracked) begin
                    $error("tracked_out expected %0d got %0d", want.tracked,
                           out_if.tracked_out);
                    n_err++;
                end
                if (out_if.rate_out !== want.rate) begin
                    $error("rate_out expected %0d got %0d", want.rate, out_if.rate_out);
                    n_err++;
                end
                if (out_if.rebuilt !== want.rebuilt) begin
                    $error("rebuilt expected %0d got %0d", want.rebuilt, out_if.rebuilt);
                    n_err++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > RUN_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFGW-1:0] data);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            CFG_ACCEL:   accel_r   = {33'b0, data[30:0]};
            CFG_PERIOD:  period_dt = {32'b0, data};
            CFG_HORIZON: horizon_h = {32'b0, data};
            default: ;
        endcase
        cfg_if.valid <= 1'b0;
    endtask

    task automatic set_gains(logic [CFGW-1:0] r, logic [CFGW-1:0] dt,
                             logic [CFGW-1:0] h);
        write_reg(CFG_ACCEL, r);
        write_reg(CFG_PERIOD, dt);
        write_reg(CFG_HORIZON, h);
    endtask

    task automatic drain();
        while (send_q.size() != 0 || result_q.size() != 0 || in_if.valid)
            @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    function automatic void push_word(logic [OPW-1:0] op, logic signed [SW-1:0] s);
        td_word_t w;
        w.op = op;
        w.sample = s;
        send_q.push_back(w);
    endfunction

    // mostly steps that follow a drifting target, with some noise
    function automatic void push_track_run(int n);
        logic signed [SW-1:0] target, delta;
        int                   pick;
        target = $urandom_range(0, 1) ? $urandom : $signed($urandom_range(0, 65536 * 64))
                 - 32'sd2097152;
        push_word(OP_PRELOAD, target);
        for (int i = 0; i < n; i++) begin
            pick  = $urandom_range(0, 99);
            delta = $signed($urandom) >>> $urandom_range(4, 31);
            if (pick < 80) begin
                target = target + delta;
                push_word(OP_STEP, target);
            end else if (pick < 88) begin
                push_word(OP_STEP, $urandom);
            end else if (pick < 93) begin
                target = $urandom;
                push_word(OP_PRELOAD, target);
            end else if (pick < 97) begin
                push_word(OP_CLEAR, $urandom);
            end else begin
                push_word(OP_HOLD, $urandom);
            end
        end
    endfunction

    initial begin
        logic [CFGW-1:0] gains[8][3];
        i_rst_n      <= 1'b0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= CFG_ACCEL;
        cfg_if.data  <= '0;
        accel_r      = 64'(R_FALLBACK);
        period_dt    = 64'(DT_FALLBACK);
        horizon_h    = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, every operation, unprimed step, rebuild
        push_word(OP_STEP, 32'sh7FFF_FFFF);
        push_word(OP_STEP, 32'sh8000_0000);
        push_word(OP_STEP, 32'sh0000_0000);
        push_word(OP_HOLD, 32'sh1234_5678);
        push_word(OP_PRELOAD, 32'sh8000_0000);
        push_word(OP_STEP, 32'sh7FFF_FFFF);
        push_word(OP_STEP, 32'sh7FFF_FFFF);
        push_word(OP_CLEAR, 32'shFFFF_FFFF);
        push_word(OP_STEP, 32'sh0001_0000);
        push_word(OP_STEP, 32'sh0001_0000);
        push_word(OP_STEP, 32'shFFFF_0000);
        push_word(OP_PRELOAD, 32'sh7FFF_0000);
        push_word(OP_STEP, 32'sh8000_0000);
        drain();
        set_gains(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_word(OP_PRELOAD, 32'sh7000_0000);
        push_word(OP_STEP, 32'sh8000_0000);
        push_word(OP_STEP, 32'sh8000_0000);
        push_word(OP_STEP, 32'sh7FFF_FFFF);
        push_word(OP_STEP, 32'sh0000_0001);
        drain();
        set_gains(32'd1, 32'd1, 32'd1);
        push_word(OP_PRELOAD, 32'sh0000_0000);
        push_word(OP_STEP, 32'sh0000_0000);
        push_word(OP_STEP, 32'sh7FFF_FFFF);
        drain();

        // random phases across gain settings
        gains[0] = '{32'd65536, 32'd4294967, 32'd0};
        gains[1] = '{32'h7FFF_FFFF, 32'd42949673, 32'd0};
        gains[2] = '{32'd0, 32'd1000, 32'd5};
        gains[3] = '{32'd6553600, 32'd0, 32'hFFFF_FFFF};
        gains[4] = '{32'd1, 32'd1, 32'd1};
        gains[5] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0};
        gains[6] = '{32'd3276800, 32'd429496730, 32'd858993459};
        gains[7] = '{32'd65536000, 32'd42949673, 32'd1};
        for (int p = 0; p < 8; p++) begin
            set_gains(gains[p][0], gains[p][1], gains[p][2]);
            for (int k = 0; k < 7; k++) push_track_run(30);
            drain();
        end

        if (n_err == 0 && result_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire
